@@ rtl/core/fba_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types for the frame bitmap allocator.
// No dependencies; every other file in rtl/core imports this package.
package fba_pkg;

    // Geometry
    localparam int unsigned MAX_FRAMES_DEF = 4096;
    localparam int unsigned WORD_BITS      = 32;
    localparam int unsigned BIT_W          = $clog2(WORD_BITS);
    localparam int unsigned FRAME_W        = 12;
    localparam int unsigned COUNT_W        = 13;
    localparam int unsigned OP_W           = 2;
    localparam int unsigned STATUS_W       = 2;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

    // Request kinds
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOM  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // request beat taken this cycle
        logic clr_step;   // zero one map word, advance pointer
        logic scan_next;  // step scan to next word
        logic set_bit;    // commit first-fit grant
        logic oom;        // scan exhausted
        logic rmw;        // free / test on fetched word
        logic load_out;   // move pending result to output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;   // last word of clearing pass
        logic imm;        // incoming request resolves without the map
        logic is_alloc;   // incoming request is an alloc
        logic word_free;  // fetched word has a clear bit
        logic scan_last;  // current word is the last one in range
        logic out_free;   // output register can take a result
    } t_sts;

    // Result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  granted_frame;
        logic                present;
        logic                read_write;
        logic                user_mode;
        logic                in_use;
    } t_rsp;

    // Lowest clear bit of a map word
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/fba_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready) of the allocator.
// Depends on fba_pkg for field widths.
interface fba_req_if import fba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [FRAME_W-1:0] frame_number;
    logic               is_kernel;
    logic               is_writeable;

    modport source (output valid, op, frame_number, is_kernel, is_writeable, input ready);
    modport sink   (input valid, op, frame_number, is_kernel, is_writeable, output ready);
endinterface

interface fba_rsp_if import fba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  granted_frame;
    logic                present;
    logic                read_write;
    logic                user_mode;
    logic                in_use;

    modport source (output valid, status, granted_frame, present, read_write, user_mode,
                    in_use, input ready);
    modport sink   (input valid, status, granted_frame, present, read_write, user_mode,
                    in_use, output ready);
endinterface

@@ rtl/core/fba_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing state machine of the allocator: clearing pass, scan, RMW, hand-off.
// Depends on fba_pkg (t_cmd, t_sts).
module fba_ctrl import fba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CLEAR  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_MODIFY = 5'b01000,
        S_HOLD   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.imm) begin
                        n_state = S_HOLD;
                    end else if (i_sts.is_alloc) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_MODIFY;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.word_free) begin
                    o_cmd.set_bit = 1'b1;
                    n_state       = S_HOLD;
                end else if (i_sts.scan_last) begin
                    o_cmd.oom = 1'b1;
                    n_state   = S_HOLD;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_MODIFY: begin
                o_cmd.rmw = 1'b1;
                n_state   = S_HOLD;
            end
            S_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready)
        else $error("request taken during clearing pass");

    a_clear_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_sts.clr_last) |=> (r_state == S_IDLE))
        else $error("clearing pass did not hand over to idle");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_state == S_SCAN || r_state == S_HOLD))
        else $error("scan left to an unexpected state");

endmodule

@@ rtl/core/fba_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the allocator: bitmap memory, scan pointer, result and output registers.
// Depends on fba_pkg (constants, t_cmd, t_sts, t_rsp, first_zero).
module fba_datapath import fba_pkg::*; #(
    parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [COUNT_W-1:0]  i_cfg_wr_data,
    input  logic [OP_W-1:0]     i_op,
    input  logic [FRAME_W-1:0]  i_frame_number,
    input  logic                i_is_kernel,
    input  logic                i_is_writeable,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_rsp_ready,
    output logic                o_rsp_valid,
    output t_rsp                o_rsp
);

    localparam int unsigned MAP_WORDS = MAX_FRAMES / WORD_BITS;
    localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned CW        = AW + 1;
    localparam int unsigned FNW_W     = FRAME_W - BIT_W;
    localparam int unsigned FCW_W     = COUNT_W - BIT_W;

    // Bitmap store
    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    logic [AW-1:0]        rd_addr;

    // Control and payload registers
    logic [COUNT_W-1:0]   r_frame_count;
    logic [CW-1:0]        r_scan, n_scan;
    logic [CW-1:0]        r_lim, n_lim;
    logic [OP_W-1:0]      r_op;
    logic [FRAME_W-1:0]   r_frame;
    logic                 r_kernel;
    logic                 r_write;
    t_rsp                 r_res;
    t_rsp                 r_out;
    logic                 r_ovalid;

    // Decode of the incoming beat
    logic [FNW_W-1:0]     fn_word;
    logic [FCW_W-1:0]     fc_words;
    logic                 in_range;
    logic                 imm;
    t_rsp                 imm_res;
    logic [CW-1:0]        scan_inc;
    logic [BIT_W-1:0]     free_bit;
    logic [BIT_W-1:0]     req_bit;
    logic [CW+BIT_W-1:0]  grant_full;

    assign fn_word    = i_frame_number[FRAME_W-1:BIT_W];
    assign fc_words   = r_frame_count[COUNT_W-1:BIT_W];
    assign in_range   = (32'(fn_word) < MAP_WORDS);
    assign n_lim      = (32'(fc_words) > MAP_WORDS) ? CW'(MAP_WORDS) : CW'(fc_words);
    assign scan_inc   = CW'(r_scan + 1'b1);
    assign free_bit   = first_zero(r_rdata);
    assign req_bit    = r_frame[BIT_W-1:0];
    assign grant_full = {r_scan, free_bit};

    // Requests settled without touching the map
    always_comb begin
        imm     = 1'b0;
        imm_res = '0;
        imm_res.status = ST_SKIP;
        unique case (i_op)
            OP_ALLOC: begin
                if (i_frame_number != '0) begin
                    imm = 1'b1;
                end else if (n_lim == '0) begin
                    imm            = 1'b1;
                    imm_res.status = ST_OOM;
                end
            end
            OP_FREE: begin
                if (i_frame_number == '0) begin
                    imm = 1'b1;
                end else if (!in_range) begin
                    imm            = 1'b1;
                    imm_res.status = ST_DONE;
                end
            end
            OP_TEST: begin
                if (!in_range) begin
                    imm            = 1'b1;
                    imm_res.status = ST_DONE;
                end
            end
            default: begin
                imm = 1'b1;
            end
        endcase
    end

    // Status to controller
    always_comb begin
        o_sts.clr_last  = (r_scan == CW'(MAP_WORDS - 1));
        o_sts.imm       = imm;
        o_sts.is_alloc  = (i_op == OP_ALLOC);
        o_sts.word_free = (r_rdata != '1);
        o_sts.scan_last = (scan_inc == r_lim);
        o_sts.out_free  = !r_ovalid || i_rsp_ready;
    end

    // Memory port control
    always_comb begin
        mem_wa = r_scan[AW-1:0];
        mem_we = i_cmd.clr_step || i_cmd.set_bit || (i_cmd.rmw && r_op == OP_FREE);
        priority if (i_cmd.clr_step) begin
            mem_wd = '0;
        end else if (i_cmd.set_bit) begin
            mem_wd = r_rdata | (WORD_BITS'(1) << free_bit);
        end else begin
            mem_wd = r_rdata & ~(WORD_BITS'(1) << req_bit);
        end
        priority if (i_cmd.accept) begin
            rd_addr = (i_op == OP_ALLOC) ? '0 : AW'(fn_word);
        end else begin
            rd_addr = scan_inc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Scan pointer: clear sweep, scan word, or word of a free/test
    always_comb begin
        n_scan = r_scan;
        priority if (i_cmd.accept) begin
            n_scan = (i_op == OP_ALLOC) ? '0 : CW'(fn_word);
        end else if (i_cmd.clr_step || i_cmd.scan_next) begin
            n_scan = scan_inc;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan        <= '0;
            r_frame_count <= FRAME_COUNT_RST;
            r_ovalid      <= 1'b0;
        end else begin
            r_scan <= n_scan;
            if (i_cfg_wr_en) begin
                r_frame_count <= i_cfg_wr_data;
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Request capture and result build
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_op;
            r_frame  <= i_frame_number;
            r_kernel <= i_is_kernel;
            r_write  <= i_is_writeable;
            r_lim    <= n_lim;
        end
        priority if (i_cmd.accept) begin
            r_res <= imm_res;
        end else if (i_cmd.set_bit) begin
            r_res.status        <= ST_DONE;
            r_res.granted_frame <= FRAME_W'(grant_full);
            r_res.present       <= 1'b1;
            r_res.read_write    <= r_write;
            r_res.user_mode     <= ~r_kernel;
            r_res.in_use        <= 1'b0;
        end else if (i_cmd.oom) begin
            r_res <= '{status: ST_OOM, granted_frame: '0, present: 1'b0,
                       read_write: 1'b0, user_mode: 1'b0, in_use: 1'b0};
        end else if (i_cmd.rmw) begin
            r_res <= '{status: ST_DONE, granted_frame: '0, present: 1'b0,
                       read_write: 1'b0, user_mode: 1'b0,
                       in_use: (r_op == OP_TEST) ? r_rdata[req_bit] : 1'b0};
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_out;

    // Checks
    a_grant_from_free_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_bit |-> (r_rdata != '1))
        else $error("grant taken from a full word");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_next |-> (({1'b0, r_scan} + 1'b1) < {1'b0, r_lim}))
        else $error("scan stepped past the frame count");

    a_grant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_bit |=> (r_res.present && r_res.status == ST_DONE))
        else $error("grant did not produce a done result");

endmodule

@@ rtl/core/frame_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the first-fit frame bitmap allocator.
// Depends on fba_pkg, fba_if (fba_req_if, fba_rsp_if), fba_ctrl and fba_datapath.
//
//  channel    dir  handshake           beat contents
//  i_req      in   valid/ready         op, frame_number, is_kernel, is_writeable
//  o_rsp      out  valid/ready         status, granted_frame, present, read_write,
//                                      user_mode, in_use
//  i_cfg_*    in   write enable only   frame_count (13 bits)
//
// Sequence: alloc reads map words in turn (one word per cycle through the single
// memory read port) to the first clear bit or the range end; free and test do one
// read-modify-write; skipped, out-of-range and empty-range requests bypass the map.
// One request is in flight at a time. Reset: a clearing pass zeroes the map at one
// word per cycle, with i_req.ready low; frame_count returns to 4096.
// Stalls: a finished result waits in the output register while the next
// request is taken; it leaves that register only when o_rsp.ready is high.
module frame_bitmap_allocator import fba_pkg::*; #(
    parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [COUNT_W-1:0]  i_cfg_wr_data,
    fba_req_if.sink             i_req,
    fba_rsp_if.source           o_rsp
);

    t_cmd cmd;
    t_sts sts;
    t_rsp rsp;
    logic rsp_valid;

    // Sequencer
    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Map and result path
    fba_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_op           (i_req.op),
        .i_frame_number (i_req.frame_number),
        .i_is_kernel    (i_req.is_kernel),
        .i_is_writeable (i_req.is_writeable),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (rsp_valid),
        .o_rsp          (rsp)
    );

    // Response channel
    assign o_rsp.valid         = rsp_valid;
    assign o_rsp.status        = rsp.status;
    assign o_rsp.granted_frame = rsp.granted_frame;
    assign o_rsp.present       = rsp.present;
    assign o_rsp.read_write    = rsp.read_write;
    assign o_rsp.user_mode     = rsp.user_mode;
    assign o_rsp.in_use        = rsp.in_use;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for frame_bitmap_allocator: drives alloc, free and test requests
// with random idling on both channels and checks every result beat against its own
// bitmap predictor. Depends on fba_pkg and the fba_req_if / fba_rsp_if interfaces.
module tb_top;
    import fba_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE        = 2'd3;  // request kind with no meaning
    localparam int unsigned     MAP_WORDS      = MAX_FRAMES_DEF / WORD_BITS;
    localparam int unsigned     WATCHDOG_LIMIT = 4000;
    localparam int unsigned     SETTLE_CYCLES  = 200;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;

    fba_req_if req_if ();
    fba_rsp_if rsp_if ();

    frame_bitmap_allocator i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    // Predictor state: one used bit per frame and the managed frame count
    logic [WORD_BITS-1:0] frame_used [MAP_WORDS];
    logic [COUNT_W-1:0]   managed_frames = FRAME_COUNT_RST;

    t_rsp               awaited_rsp [$];   // results still owed by the block, oldest first
    logic [FRAME_W-1:0] handed_out  [$];   // frames granted and not yet released by us

    int unsigned gap_pct      = 0;         // chance of a sender gap before a beat
    int unsigned stall_pct    = 0;         // chance of a receiver stall burst
    int unsigned stall_run    = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches   = 0;
    int unsigned n_req = 0, n_grant = 0, n_oom = 0, n_skip = 0, n_in_use = 0, n_cfg = 0;

    t_rsp got_rsp;
    t_rsp want_rsp;

    always #5 clk = ~clk;

    // Work out the result of one accepted request and update the predicted bitmap
    function automatic t_rsp resolve_request(input logic [OP_W-1:0] op,
                                             input logic [FRAME_W-1:0] frame,
                                             input logic kern, input logic wr);
        t_rsp        r;
        int unsigned span;
        int unsigned hit;
        logic        found;
        r        = '0;
        r.status = ST_SKIP;
        found    = 1'b0;
        hit      = 0;
        case (op)
            OP_ALLOC: begin
                if (frame == '0) begin
                    // first fit over whole words below the count, capped at the map size
                    span = (managed_frames > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : managed_frames;
                    span = span / WORD_BITS;
                    for (int w = 0; w < span && !found; w++) begin
                        for (int b = 0; b < WORD_BITS && !found; b++) begin
                            if (!frame_used[w][b]) begin
                                found = 1'b1;
                                hit   = w * WORD_BITS + b;
                            end
                        end
                    end
                    if (found) begin
                        frame_used[hit / WORD_BITS][hit % WORD_BITS] = 1'b1;
                        r.status        = ST_DONE;
                        r.granted_frame = hit[FRAME_W-1:0];
                        r.present       = 1'b1;
                        r.read_write    = wr;
                        r.user_mode     = ~kern;
                    end else begin
                        r.status = ST_OOM;
                    end
                end
            end
            OP_FREE: begin
                if (frame != '0) begin
                    r.status = ST_DONE;
                    frame_used[frame[FRAME_W-1:BIT_W]][frame[BIT_W-1:0]] = 1'b0;
                end
            end
            OP_TEST: begin
                r.status = ST_DONE;
                r.in_use = frame_used[frame[FRAME_W-1:BIT_W]][frame[BIT_W-1:0]];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one request beat, wait for it to be taken, then record its result
    task automatic send_request(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] frame,
                                input logic kern, input logic wr);
        t_rsp r;
        @(negedge clk);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= op;
        req_if.frame_number <= frame;
        req_if.is_kernel    <= kern;
        req_if.is_writeable <= wr;
        do @(posedge clk); while (!req_if.ready);
        r = resolve_request(op, frame, kern, wr);
        awaited_rsp.push_back(r);
        n_req++;
        if (r.status == ST_SKIP) n_skip++;
        if (r.status == ST_OOM) n_oom++;
        if (r.in_use) n_in_use++;
        if (op == OP_ALLOC && r.status == ST_DONE) begin
            n_grant++;
            handed_out.push_back(r.granted_frame);
        end
    endtask

    // Hold the sender off until every owed result has come back
    task automatic wait_for_results();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_frame_count(input logic [COUNT_W-1:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        managed_frames = value;
        n_cfg++;
    endtask

    // Random traffic: mostly allocs and releases of granted frames, some tests, some noise
    task automatic mixed_traffic(input int unsigned n_items, input int unsigned idle_pct);
        int unsigned        pick;
        int unsigned        idx;
        logic [FRAME_W-1:0] f;
        for (int i = 0; i < n_items; i++) begin
            // idling switched on and off in stretches
            if (i % 64 == 0) begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_request(OP_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 72) begin
                if (handed_out.size() > 0) begin
                    idx = $urandom_range(0, handed_out.size() - 1);
                    f   = handed_out[idx];
                    handed_out.delete(idx);
                end else begin
                    f = FRAME_W'($urandom_range(0, 4095));
                end
                send_request(OP_FREE, f, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 87) begin
                if (handed_out.size() > 0 && $urandom_range(0, 1) == 0)
                    f = handed_out[$urandom_range(0, handed_out.size() - 1)];
                else
                    f = FRAME_W'($urandom_range(0, 4095));
                send_request(OP_TEST, f, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                // noise: skipped allocs, frame-zero frees, meaningless ops, stray frees
                case ($urandom_range(0, 3))
                    0: send_request(OP_ALLOC, FRAME_W'($urandom_range(1, 4095)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    1: send_request(OP_FREE, '0, 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)));
                    2: send_request(OP_NONE, FRAME_W'($urandom_range(0, 4095)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    default: send_request(OP_FREE, FRAME_W'($urandom_range(0, 4095)),
                                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                endcase
            end
            if ($urandom_range(0, 149) == 0) wait_for_results();
        end
    endtask

    // Each request kind and the skip cases on the reset frame count
    task automatic test_basic_requests();
        send_request(OP_TEST, '0, 1'b0, 1'b0);
        // empty map: first grant is frame zero
        send_request(OP_ALLOC, '0, 1'b1, 1'b0);
        send_request(OP_ALLOC, '0, 1'b0, 1'b1);
        send_request(OP_ALLOC, '0, 1'b1, 1'b1);
        send_request(OP_TEST, 12'd1, 1'b0, 1'b0);
        send_request(OP_TEST, '1, 1'b1, 1'b1);
        // page already has a frame
        send_request(OP_ALLOC, '1, 1'b1, 1'b1);
        send_request(OP_ALLOC, 12'd1, 1'b0, 1'b0);
        // frame zero is never freed
        send_request(OP_FREE, '0, 1'b1, 1'b1);
        send_request(OP_FREE, 12'd1, 1'b0, 1'b0);
        send_request(OP_TEST, 12'd1, 1'b0, 1'b0);
        send_request(OP_FREE, '1, 1'b0, 1'b0);
        send_request(OP_ALLOC, '0, 1'b0, 1'b0);
        send_request(OP_NONE, '1, 1'b1, 1'b1);
        send_request(OP_NONE, '0, 1'b0, 1'b0);
    endtask

    // Scan range at the frame count extremes
    task automatic test_scan_limits();
        write_frame_count('0);
        send_request(OP_ALLOC, '0, 1'b0, 1'b1);
        write_frame_count(13'd31);
        send_request(OP_ALLOC, '0, 1'b1, 1'b0);
        write_frame_count(13'd33);
        send_request(OP_ALLOC, '0, 1'b0, 1'b0);
        send_request(OP_ALLOC, '0, 1'b1, 1'b1);
        write_frame_count('1);
        send_request(OP_ALLOC, '0, 1'b0, 1'b1);
        write_frame_count(FRAME_COUNT_RST);
        send_request(OP_ALLOC, '0, 1'b1, 1'b0);
    endtask

    // Small maps filled to exhaustion and drained again
    task automatic test_fill_and_release();
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: write_frame_count(13'd32);
                1: write_frame_count(13'd64);
                2: write_frame_count(13'd96);
                default: write_frame_count(COUNT_W'($urandom_range(33, 256)));
            endcase
            mixed_traffic(250, 30);
        end
    endtask

    // Full-size map, also with a count beyond the map size
    task automatic test_wide_map();
        write_frame_count(FRAME_COUNT_RST);
        mixed_traffic(200, 20);
        write_frame_count('1);
        mixed_traffic(200, 20);
    endtask

    // Back-to-back beats on both channels
    task automatic test_no_idling();
        write_frame_count(13'd160);
        mixed_traffic(200, 0);
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    // Result-side ready, dropped in random stall bursts
    always @(negedge clk) begin
        if (stall_run > 0) begin
            stall_run    <= stall_run - 1;
            rsp_if.ready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_run    <= $urandom_range(0, 8);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [FRAME_W-1:0] want,
                               input logic [FRAME_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result beat with the oldest owed result
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got_rsp = '{status: rsp_if.status, granted_frame: rsp_if.granted_frame,
                        present: rsp_if.present, read_write: rsp_if.read_write,
                        user_mode: rsp_if.user_mode, in_use: rsp_if.in_use};
            if (awaited_rsp.size() == 0) begin
                $display("%0t ns: result beat with none owed, expected nothing, got %p",
                         $time, got_rsp);
                mismatches++;
            end else begin
                want_rsp = awaited_rsp.pop_front();
                check_field("status", FRAME_W'(want_rsp.status), FRAME_W'(got_rsp.status));
                check_field("granted_frame", want_rsp.granted_frame, got_rsp.granted_frame);
                check_field("present", FRAME_W'(want_rsp.present), FRAME_W'(got_rsp.present));
                check_field("read_write", FRAME_W'(want_rsp.read_write),
                            FRAME_W'(got_rsp.read_write));
                check_field("user_mode", FRAME_W'(want_rsp.user_mode),
                            FRAME_W'(got_rsp.user_mode));
                check_field("in_use", FRAME_W'(want_rsp.in_use), FRAME_W'(got_rsp.in_use));
            end
        end
    end

    // Watchdog: too long without a beat on either channel
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog, no beat for %0d cycles, %0d results owed",
                     $time, WATCHDOG_LIMIT, awaited_rsp.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Reset, tests in turn, then the verdict
    initial begin
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        req_if.valid        <= 1'b0;
        req_if.op           <= OP_ALLOC;
        req_if.frame_number <= '0;
        req_if.is_kernel    <= 1'b0;
        req_if.is_writeable <= 1'b0;
        foreach (frame_used[w]) frame_used[w] = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_basic_requests();
        test_scan_limits();
        test_fill_and_release();
        test_wide_map();
        test_no_idling();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d requests: %0d grants, %0d out of frames, %0d skipped.",
                 n_req, n_grant, n_oom, n_skip);
        $display("Tests that found a frame in use: %0d; frame count written %0d times.",
                 n_in_use, n_cfg);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/fba_pkg.sv
rtl/core/fba_if.sv
rtl/core/fba_ctrl.sv
rtl/core/fba_datapath.sv
rtl/core/frame_bitmap_allocator.sv
tb/sv/tb_top.sv
